/* rtl/tssf_pkg.sv */
// ----------------------------------------------------------------------------
// tssf_pkg: shared types and constants for the tensor slice stream filter
// Register indexes, lane layout of the packed bound registers and the
// record passed from cell to cell along the coordinate chain.
// ----------------------------------------------------------------------------
package tssf_pkg;

   localparam int LANE_W      = 16;
   localparam int NUM_LANES   = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int ELEM_W      = 32;
   localparam int RANK_W      = 3;
   localparam int AXIS_W      = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_RANK         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DIM_SIZES    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_START_BOUNDS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_END_BOUNDS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_LIST    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_COUNT   = 3'd5;

   // record handed from an inner axis cell to the next outer one
   typedef struct packed {
      logic carry;   // all inner axes wrap on this request
      logic sel;     // all inner axes inside their range
      logic last;    // all inner axes on their final selected coordinate
   } chain_type;

endpackage

/* rtl/tssf_bounds.sv */
// ----------------------------------------------------------------------------
// tssf_bounds: configuration registers and per-axis range resolution
// Holds the control registers and turns the listed starts and ends into a
// clamped [lo, hi) range for every axis in use.
// ----------------------------------------------------------------------------
module tssf_bounds #(
   parameter int MAX_DIMS = 4,
   parameter int DIM_BITS = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [tssf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tssf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                             cfg_clear,
   output logic                             axis_active [MAX_DIMS],
   output logic [DIM_BITS-1:0]              axis_size   [MAX_DIMS],
   output logic [DIM_BITS-1:0]              axis_lo     [MAX_DIMS],
   output logic [DIM_BITS-1:0]              axis_hi     [MAX_DIMS]
);
   import tssf_pkg::*;

   logic [RANK_W-1:0]           rank_ff;
   logic [CSR_DATA_W-1:0]       dim_sizes_ff;
   logic [CSR_DATA_W-1:0]       start_bounds_ff;
   logic [CSR_DATA_W-1:0]       end_bounds_ff;
   logic [2*NUM_LANES-1:0]      axis_list_ff;
   logic [RANK_W-1:0]           axis_count_ff;

   logic [RANK_W-1:0]           eff_rank;
   logic [RANK_W-1:0]           entry_cnt;
   logic                        all_axes;
   logic [AXIS_W-1:0]           entry_ax [NUM_LANES];

   // start or end lane made ready against axis size n
   function automatic logic [DIM_BITS-1:0] norm_bound(
      input logic signed [LANE_W-1:0] s,
      input logic [DIM_BITS-1:0]      n
   );
      logic signed [LANE_W+1:0] sx;
      logic signed [LANE_W+1:0] nx;
      logic signed [LANE_W+1:0] sum;
      sx  = (LANE_W+2)'(s);
      nx  = signed'((LANE_W+2)'(n));
      sum = sx + nx;
      if (sx > nx) begin
         return n;
      end else if (s[LANE_W-1]) begin
         if (sum[LANE_W+1]) begin
            return '0;
         end else begin
            return sum[DIM_BITS-1:0];
         end
      end else begin
         return s[DIM_BITS-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff         <= RANK_W'(1);
         dim_sizes_ff    <= '0;
         start_bounds_ff <= '0;
         end_bounds_ff   <= '0;
         axis_list_ff    <= '0;
         axis_count_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_RANK:         rank_ff         <= csr_wdata[RANK_W-1:0];
            REG_DIM_SIZES:    dim_sizes_ff    <= csr_wdata;
            REG_START_BOUNDS: start_bounds_ff <= csr_wdata;
            REG_END_BOUNDS:   end_bounds_ff   <= csr_wdata;
            REG_AXIS_LIST:    axis_list_ff    <= csr_wdata[2*NUM_LANES-1:0];
            REG_AXIS_COUNT:   axis_count_ff   <= csr_wdata[RANK_W-1:0];
            default: ;
         endcase
      end
   end

   // any write to a defined register starts a new tensor
   assign cfg_clear = csr_wr_en && (csr_index <= REG_AXIS_COUNT);

   always_comb begin
      if (rank_ff == '0) begin
         eff_rank = RANK_W'(1);
      end else if (rank_ff > RANK_W'(MAX_DIMS)) begin
         eff_rank = RANK_W'(MAX_DIMS);
      end else begin
         eff_rank = rank_ff;
      end
      all_axes = (axis_count_ff == '0);
      if (all_axes) begin
         entry_cnt = eff_rank;
      end else if (axis_count_ff > RANK_W'(NUM_LANES)) begin
         entry_cnt = RANK_W'(NUM_LANES);
      end else begin
         entry_cnt = axis_count_ff;
      end
      for (int i = 0; i < NUM_LANES; i++) begin
         entry_ax[i] = all_axes ? AXIS_W'(i) : axis_list_ff[AXIS_W*i +: AXIS_W];
      end
   end

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_axis
      logic                     hit;
      logic [AXIS_W-1:0]        hit_idx;
      logic [DIM_BITS-1:0]      size_raw;
      logic [DIM_BITS-1:0]      size_eff;
      logic signed [LANE_W-1:0] start_lane;
      logic signed [LANE_W-1:0] end_lane;

      assign size_raw = dim_sizes_ff[LANE_W*d +: DIM_BITS];
      assign size_eff = (size_raw == '0) ? DIM_BITS'(1) : size_raw;

      // later list entries override earlier ones
      always_comb begin
         hit     = 1'b0;
         hit_idx = '0;
         for (int i = 0; i < NUM_LANES; i++) begin
            if ((RANK_W'(i) < entry_cnt) && (entry_ax[i] == AXIS_W'(d))
                && (RANK_W'(d) < eff_rank)) begin
               hit     = 1'b1;
               hit_idx = AXIS_W'(i);
            end
         end
      end

      assign start_lane = start_bounds_ff[LANE_W*hit_idx +: LANE_W];
      assign end_lane   = end_bounds_ff[LANE_W*hit_idx +: LANE_W];

      assign axis_active[d] = (RANK_W'(d) < eff_rank);
      assign axis_size[d]   = size_eff;
      assign axis_lo[d]     = hit ? norm_bound(start_lane, size_eff) : '0;
      assign axis_hi[d]     = hit ? norm_bound(end_lane, size_eff) : size_eff;
   end

endmodule

/* rtl/tssf_cell.sv */
// ----------------------------------------------------------------------------
// tssf_cell: one axis of the coordinate chain
// Holds the coordinate of one axis, checks it against the axis range and
// steps it when every inner axis wraps.
// ----------------------------------------------------------------------------
module tssf_cell #(
   parameter int DIM_BITS = 15
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      active,
   input  logic [DIM_BITS-1:0]       size,
   input  logic [DIM_BITS-1:0]       lo,
   input  logic [DIM_BITS-1:0]       hi,
   input  logic                      clear,
   input  logic                      advance,
   input  tssf_pkg::chain_type       chain_i,
   output tssf_pkg::chain_type       chain_o
);
   import tssf_pkg::*;

   logic [DIM_BITS-1:0] counter_ff;
   logic [DIM_BITS-1:0] counter_in;
   logic [DIM_BITS:0]   count_inc;
   logic                wrap;
   logic                in_range;
   logic                at_last;

   assign count_inc = {1'b0, counter_ff} + (DIM_BITS+1)'(1);
   assign wrap      = count_inc >= {1'b0, size};
   assign in_range  = (counter_ff >= lo) && (counter_ff < hi);
   // an empty range (hi of zero) never matches here
   assign at_last   = count_inc == {1'b0, hi};

   // axes beyond the rank pass the chain through untouched
   assign chain_o.carry = chain_i.carry && (!active || wrap);
   assign chain_o.sel   = chain_i.sel   && (!active || in_range);
   assign chain_o.last  = chain_i.last  && (!active || at_last);

   always_comb begin
      counter_in = counter_ff;
      if (clear) begin
         counter_in = '0;
      end else if (advance && active && chain_i.carry) begin
         counter_in = wrap ? '0 : count_inc[DIM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else begin
         counter_ff <= counter_in;
      end
   end

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      clear |=> (counter_ff == '0))
      else $error("coordinate not cleared after register write");

   a_counter_in_size: assert property (@(posedge clock) disable iff (reset)
      active |-> (counter_ff < size))
      else $error("coordinate outside axis size");

   a_idle_axis_holds: assert property (@(posedge clock) disable iff (reset)
      (!active && !clear) |=> $stable(counter_ff))
      else $error("coordinate of an unused axis moved");

endmodule

/* rtl/tensor_slice_stream_filter.sv */
// ----------------------------------------------------------------------------
// tensor_slice_stream_filter: slice selection over a streamed tensor
// Takes tensor elements in row-major order and forwards only those whose
// coordinates fall inside the configured slice on every axis.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one 32-bit element per request, row-major, innermost axis
//   fastest. rsp_* carries each selected element unchanged with rsp_out_last
//   set on the final selected element of the tensor.
//   csr_* writes the control registers (rank, sizes, starts, ends, axis list,
//   axis count); any write to a defined register restarts the coordinate
//   counters at the first element of a new tensor. Write only while idle.
//   A response appears in the cycle after its request is taken; a request is
//   taken every cycle while req_stall is low. The coordinate step and range
//   checks run through the chain of axis cells in the same cycle, and the
//   response sits in one output register, refilled in the cycle it is taken.
//   req_stall rises only while a response is held and rsp_stall is high.
//   Reset loads rank 1 and clears all other registers and the counters.
//   After the last element of a tensor the counters wrap to zero.
// ----------------------------------------------------------------------------
module tensor_slice_stream_filter #(
   parameter int MAX_DIMS = 4,
   parameter int DIM_BITS = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tssf_pkg::ELEM_W-1:0]      req_elem_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tssf_pkg::ELEM_W-1:0]      rsp_out_value,
   output logic                             rsp_out_last,
   input  logic                             csr_wr_en,
   input  logic [tssf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tssf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tssf_pkg::*;

   logic                cfg_clear;
   logic                axis_active [MAX_DIMS];
   logic [DIM_BITS-1:0] axis_size   [MAX_DIMS];
   logic [DIM_BITS-1:0] axis_lo     [MAX_DIMS];
   logic [DIM_BITS-1:0] axis_hi     [MAX_DIMS];
   chain_type           link        [MAX_DIMS+1];

   logic                accept;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [ELEM_W-1:0]   rsp_value_ff;
   logic                rsp_last_ff;

   tssf_bounds #(
      .MAX_DIMS (MAX_DIMS),
      .DIM_BITS (DIM_BITS)
   ) u_bounds (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg_clear   (cfg_clear),
      .axis_active (axis_active),
      .axis_size   (axis_size),
      .axis_lo     (axis_lo),
      .axis_hi     (axis_hi)
   );

   // innermost axis sits at the head of the chain and always steps
   assign link[MAX_DIMS] = '{carry: 1'b1, sel: 1'b1, last: 1'b1};

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
      tssf_cell #(
         .DIM_BITS (DIM_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .active  (axis_active[d]),
         .size    (axis_size[d]),
         .lo      (axis_lo[d]),
         .hi      (axis_hi[d]),
         .clear   (cfg_clear),
         .advance (accept),
         .chain_i (link[d+1]),
         .chain_o (link[d])
      );
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = link[0].sel;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && link[0].sel) begin
         rsp_value_ff <= req_elem_value;
         rsp_last_ff  <= link[0].last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_last  = rsp_last_ff;

   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("response appeared without a request");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty output register");

   a_dropped_request: assert property (@(posedge clock) disable iff (reset)
      (accept && !link[0].sel && !rsp_valid_ff) |=> !rsp_valid)
      else $error("unselected request produced a response");

endmodule

/* tb/tb_tensor_slice_stream_filter.sv */
// ----------------------------------------------------------------------------
// tb_tensor_slice_stream_filter: self-checking bench for the slice filter
// Streams tensors through the block under a series of slice settings, keeps
// its own coordinate counters to predict which requests come out and which
// one closes the slice, and compares every response field by field.
// ----------------------------------------------------------------------------
module tb_tensor_slice_stream_filter;
   import tssf_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [ELEM_W-1:0] value;
      logic              last;
   } sel_elem_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ELEM_W-1:0]      req_elem_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ELEM_W-1:0]      rsp_out_value;
   logic                   rsp_out_last;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predicted copy of the block's registers and coordinate counters
   logic [2:0]  cfg_rank = 3'd1;
   logic [63:0] cfg_dims = '0;
   logic [63:0] cfg_starts = '0;
   logic [63:0] cfg_ends = '0;
   logic [7:0]  cfg_axes = '0;
   logic [2:0]  cfg_axis_cnt = '0;
   logic [14:0] coord [4] = '{default: '0};

   logic [ELEM_W-1:0] elem_feed [$];
   sel_elem_type      selected_elems [$];
   sel_elem_type      head_elem;

   logic req_taken = 1'b0;
   bit   no_gaps = 1'b0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   mismatch_count = 0;
   int   rsp_count = 0;
   int   items_sent = 0;

   tensor_slice_stream_filter i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_last   (rsp_out_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic int axis_len(input int d);
      int v;
      v = cfg_dims[16*d +: 15];
      return (v == 0) ? 1 : v;
   endfunction

   function automatic int eff_rank();
      if (cfg_rank == 0) return 1;
      if (cfg_rank > 4) return 4;
      return cfg_rank;
   endfunction

   // onnx style bound: wrap negatives once, then clamp into [0, n]
   function automatic int clip_bound(input logic signed [15:0] raw, input int n);
      int s;
      s = raw;
      if (s > n) return n;
      if (s < 0) begin
         s = s + n;
         if (s < 0) s = 0;
      end
      return s;
   endfunction

   task automatic slice_step(input logic [ELEM_W-1:0] elem);
      int lo [4];
      int hi [4];
      int r, n_ent, ax, d, i;
      bit sel, fin, all_axes;
      r = eff_rank();
      for (d = 0; d < r; d++) begin
         lo[d] = 0;
         hi[d] = axis_len(d);
      end
      all_axes = (cfg_axis_cnt == 0);
      n_ent = all_axes ? r : ((cfg_axis_cnt > 4) ? 4 : cfg_axis_cnt);
      for (i = 0; i < n_ent; i++) begin
         ax = all_axes ? i : cfg_axes[2*i +: 2];
         if (ax < r) begin
            lo[ax] = clip_bound(cfg_starts[16*i +: 16], axis_len(ax));
            hi[ax] = clip_bound(cfg_ends[16*i +: 16], axis_len(ax));
         end
      end
      sel = 1'b1;
      fin = 1'b1;
      for (d = 0; d < r; d++) begin
         if (int'(coord[d]) < lo[d] || int'(coord[d]) >= hi[d]) sel = 1'b0;
         if (int'(coord[d]) != hi[d] - 1) fin = 1'b0;
      end
      // innermost axis is the highest in use
      for (d = r - 1; d >= 0; d--) begin
         if (int'(coord[d]) + 1 >= axis_len(d)) begin
            coord[d] = '0;
         end else begin
            coord[d] = coord[d] + 1'b1;
            break;
         end
      end
      if (sel) selected_elems.push_back('{value: elem, last: fin});
   endtask

   task automatic note_mismatch(input string what, input logic [ELEM_W-1:0] exp_v,
                                input logic [ELEM_W-1:0] act_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %h, got %h", what, exp_v, act_v);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (elem_feed.size() > 0) begin
            req_valid      <= 1'b1;
            req_elem_value <= elem_feed.pop_front();
            send_gap       <= no_gaps ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= no_gaps ? 0 : pick_gap();
      end
   end

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) slice_step(req_elem_value);
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (selected_elems.size() == 0) begin
               note_mismatch("unexpected response", '0, rsp_out_value);
            end else begin
               head_elem = selected_elems.pop_front();
               if (rsp_out_value !== head_elem.value)
                  note_mismatch("out_value", head_elem.value, rsp_out_value);
               if (rsp_out_last !== head_elem.last)
                  note_mismatch("out_last", ELEM_W'(head_elem.last), ELEM_W'(rsp_out_last));
            end
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] data);
      bit known;
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      known = 1'b1;
      case (idx)
         REG_RANK:         cfg_rank = data[2:0];
         REG_DIM_SIZES:    cfg_dims = data;
         REG_START_BOUNDS: cfg_starts = data;
         REG_END_BOUNDS:   cfg_ends = data;
         REG_AXIS_LIST:    cfg_axes = data[7:0];
         REG_AXIS_COUNT:   cfg_axis_cnt = data[2:0];
         default:          known = 1'b0;
      endcase
      if (known) coord = '{default: '0};
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (elem_feed.size() != 0 || req_valid || selected_elems.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_elems(input int n);
      repeat (n) begin
         elem_feed.push_back($urandom());
         items_sent++;
      end
   endtask

   function automatic logic [15:0] pick_bound();
      int roll, v;
      roll = $urandom_range(0, 99);
      v = int'($urandom_range(0, 12)) - 6;
      if (roll < 70) return v[15:0];
      if (roll < 80) return 16'h7FFF;
      if (roll < 88) return 16'h8000;
      return 16'($urandom());
   endfunction

   function automatic logic [15:0] pick_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return 16'($urandom_range(1, 5));
      if (roll < 88) return 16'h0000;
      if (roll < 95) return 16'h8000 | 16'($urandom_range(1, 4));
      return 16'($urandom_range(6, 12));
   endfunction

   task automatic random_config(input bit write_all);
      logic [63:0] vals [6];
      int roll, first, k, idx;
      roll = $urandom_range(0, 99);
      vals[REG_RANK] = (roll < 85) ? 64'($urandom_range(1, 4)) : 64'($urandom_range(0, 7));
      for (k = 0; k < 4; k++) begin
         vals[REG_DIM_SIZES][16*k +: 16]    = pick_size();
         vals[REG_START_BOUNDS][16*k +: 16] = pick_bound();
         vals[REG_END_BOUNDS][16*k +: 16]   = pick_bound();
      end
      vals[REG_AXIS_LIST] = 64'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 35)      vals[REG_AXIS_COUNT] = 64'd0;
      else if (roll < 90) vals[REG_AXIS_COUNT] = 64'($urandom_range(1, 4));
      else                vals[REG_AXIS_COUNT] = 64'($urandom_range(5, 7));
      first = $urandom_range(0, 5);
      for (k = 0; k < 6; k++) begin
         idx = (first + k) % 6;
         if (write_all || $urandom_range(0, 3) != 0)
            write_reg(CSR_INDEX_W'(idx), vals[idx]);
      end
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, {$urandom(), $urandom()});
   endtask

   initial begin
      int vol, n, d;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset settings give an empty slice
      send_elems(2);
      wait_idle();

      // full 2-d tensor, ends clamped to the sizes, then wrap into a new one
      write_reg(REG_RANK, 64'd2);
      write_reg(REG_DIM_SIZES, 64'h0000_0000_0003_0002);
      write_reg(REG_END_BOUNDS, 64'h0000_0000_7FFF_7FFF);
      foreach (elem_feed[i]) elem_feed.delete();
      elem_feed.push_back(32'h0000_0000);
      elem_feed.push_back(32'hFFFF_FFFF);
      elem_feed.push_back(32'h8000_0000);
      elem_feed.push_back(32'h0000_0001);
      elem_feed.push_back(32'hAAAA_AAAA);
      elem_feed.push_back(32'h5555_5555);
      elem_feed.push_back(32'h1234_5678);
      items_sent += 7;
      wait_idle();

      // axis 1 listed twice (later wins), negative bounds, entry beyond rank
      write_reg(REG_AXIS_LIST, 64'h35);
      write_reg(REG_AXIS_COUNT, 64'd3);
      write_reg(REG_START_BOUNDS, 64'h0000_0000_FFFE_8000);
      write_reg(REG_END_BOUNDS, 64'h0000_0000_FFFF_0005);
      send_elems(3);
      wait_idle();
      // undefined index leaves the counters running
      write_reg(REG_UNUSED, '1);
      send_elems(3);
      wait_idle();

      // rank and count above range, size lane with only its top bit set
      write_reg(REG_RANK, 64'd7);
      write_reg(REG_DIM_SIZES, 64'h0002_0001_8000_0002);
      write_reg(REG_AXIS_COUNT, 64'd7);
      write_reg(REG_AXIS_LIST, 64'hE4);
      write_reg(REG_START_BOUNDS, 64'h0);
      write_reg(REG_END_BOUNDS, 64'h7FFF_7FFF_7FFF_0001);
      send_elems(5);
      wait_idle();
      write_reg(REG_RANK, 64'd0);
      send_elems(3);
      wait_idle();

      // one pass over a long axis with the size lane top bit set, tail selected, then a wrap
      no_gaps = 1'b1;
      write_reg(REG_RANK, 64'd1);
      write_reg(REG_DIM_SIZES, 64'h8190);
      write_reg(REG_AXIS_COUNT, 64'd1);
      write_reg(REG_AXIS_LIST, 64'h0);
      write_reg(REG_START_BOUNDS, 64'hFFFD);
      write_reg(REG_END_BOUNDS, 64'h7FFF);
      send_elems(400 + 4);
      wait_idle();

      random_config(1'b1);
      while (items_sent < 2000) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         vol = 1;
         for (d = 0; d < eff_rank(); d++) vol = vol * axis_len(d);
         if (vol > 300) vol = 300;
         n = vol * $urandom_range(1, 3) + $urandom_range(0, vol);
         if (n > 300) n = 300;
         send_elems(n);
         wait_idle();
         random_config(1'b0);
      end
      wait_idle();

      if (mismatch_count == 0 && selected_elems.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/tssf_pkg.sv
rtl/tssf_bounds.sv
rtl/tssf_cell.sv
rtl/tensor_slice_stream_filter.sv
tb/tb_tensor_slice_stream_filter.sv
